// ===== rtl/iecsb_pkg.sv =====
// iecsb_pkg: shared types and codes for the serial bus device state machine.
// Used by iecsb_step and iec_serial_bus_device_fsm; depends on nothing.
package iecsb_pkg;

	// bus bit-level phases, one-hot
	typedef enum logic [8:0] {
		PH_IDLE       = 9'b000000001,
		PH_ATN_WAIT   = 9'b000000010,
		PH_READY      = 9'b000000100,
		PH_RECEIVE    = 9'b000001000,
		PH_SEND_START = 9'b000010000,
		PH_SEND_WAIT  = 9'b000100000,
		PH_SEND_EOI   = 9'b001000000,
		PH_SEND_BITS  = 9'b010000000,
		PH_SEND_END   = 9'b100000000
	} iecsb_phase_t;

	// event codes reported with each word
	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_LISTEN     = 4'd1,
		EV_UNLISTEN   = 4'd2,
		EV_TALK       = 4'd3,
		EV_UNTALK     = 4'd4,
		EV_LISTEN_SEC = 4'd5,
		EV_TALK_SEC   = 4'd6,
		EV_DATA_IN    = 4'd7,
		EV_FETCH      = 4'd8
	} iecsb_event_t;

	// command bytes and command group field values
	localparam logic [7:0] CMD_GROUP_MASK = 8'h60;
	localparam logic [7:0] CMD_GROUP_LSN  = 8'h20;
	localparam logic [7:0] CMD_GROUP_TLK  = 8'h40;
	localparam logic [7:0] CMD_GROUP_SEC  = 8'h60;
	localparam logic [7:0] CMD_UNLISTEN   = 8'h3f;
	localparam logic [7:0] CMD_UNTALK     = 8'h5f;

	// timing thresholds in microseconds
	localparam logic [15:0] T_BIT_US     = 16'd60;
	localparam logic [15:0] T_EOI_LO_US  = 16'd200;
	localparam logic [15:0] T_EOI_HI_US  = 16'd260;
	localparam logic [15:0] T_EOI_TX_US  = 16'd512;

	localparam int QUIET_W = 16;
	localparam logic [6:0] CPM_RESET = 7'd8;

	// one bus sample tick
	typedef struct packed {
		logic       host_atn;
		logic       host_clk;
		logic       host_data;
		logic [7:0] elapsed_clocks;
		logic [7:0] send_byte;
		logic       send_is_last;
		logic       unlisten_not_found;
	} iecsb_tick_t;

	// one result word
	typedef struct packed {
		logic       drive_clk;
		logic       drive_data;
		logic [3:0] event_kind;
		logic [7:0] event_byte;
	} iecsb_result_t;

	// device state; quiet count saturates above every threshold
	typedef struct packed {
		iecsb_phase_t       phase;
		logic               bit_valid;
		logic [3:0]         bit_count;
		logic [7:0]         shift_byte;
		logic               is_listener;
		logic               is_talker;
		logic               in_attention;
		logic               end_of_transfer;
		logic               file_missing;
		logic [QUIET_W-1:0] quiet_clocks;
		logic [2:0]         prev_lines;
		logic               drv_clk;
		logic               drv_data;
	} iecsb_state_t;

endpackage

// ===== rtl/iecsb_step.sv =====
// iecsb_step: next-state and result logic for one bus sample tick.
// Combinational; depends on iecsb_pkg.
module iecsb_step (
	input  logic [6:0]                cpm,
	input  iecsb_pkg::iecsb_tick_t    tick,
	input  iecsb_pkg::iecsb_state_t   cur,
	output iecsb_pkg::iecsb_state_t   nxt,
	output iecsb_pkg::iecsb_result_t  res
);
	import iecsb_pkg::*;

	logic [QUIET_W:0]   sum;
	logic [QUIET_W-1:0] quiet_sat;
	logic [15:0]        thr_bit;
	logic [15:0]        thr_eoi_lo;
	logic [15:0]        thr_eoi_hi;
	logic [15:0]        thr_eoi_tx;
	logic [2:0]         lines_in;
	logic               atn;
	logic               hc;
	logic               hd;

	// thresholds scaled by clocks per microsecond
	assign thr_bit    = 16'(cpm) * T_BIT_US;
	assign thr_eoi_lo = 16'(cpm) * T_EOI_LO_US;
	assign thr_eoi_hi = 16'(cpm) * T_EOI_HI_US;
	assign thr_eoi_tx = 16'(cpm) * T_EOI_TX_US;

	assign atn = tick.host_atn;
	assign hc  = tick.host_clk;
	assign hd  = tick.host_data;

	// saturating quiet time
	assign sum       = {1'b0, cur.quiet_clocks} + (QUIET_W+1)'(tick.elapsed_clocks);
	assign quiet_sat = sum[QUIET_W] ? {QUIET_W{1'b1}} : sum[QUIET_W-1:0];

	assign lines_in = {atn, cur.drv_clk & hc, cur.drv_data & hd};

	// tick evaluation, in bus order
	always_comb begin
		iecsb_state_t n;
		logic [3:0]   ev;
		logic [7:0]   eb;
		n  = cur;
		ev = EV_NONE;
		eb = 8'd0;
		if (lines_in == cur.prev_lines) begin
			// lines quiet: timing driven actions
			n.quiet_clocks = quiet_sat;
			if (n.phase == PH_RECEIVE && n.bit_valid && n.bit_count == 4'd0
					&& 16'(n.quiet_clocks) > thr_eoi_lo) begin
				if (16'(n.quiet_clocks) < thr_eoi_hi) begin
					n.drv_data = 1'b0;
					n.end_of_transfer = 1'b1;
				end else begin
					n.drv_data = 1'b1;
					n.quiet_clocks = '0;
				end
			end
			if (n.phase == PH_SEND_START && 16'(n.quiet_clocks) > thr_bit) begin
				n.drv_clk = 1'b1;
				n.phase = PH_SEND_WAIT;
				n.quiet_clocks = '0;
			end else if (n.phase == PH_SEND_WAIT && (n.drv_data & hd) && !n.file_missing) begin
				n.quiet_clocks = '0;
				n.shift_byte = tick.send_byte;
				n.end_of_transfer = tick.send_is_last;
				n.bit_count = 4'd0;
				n.bit_valid = 1'b1;
				ev = EV_FETCH;
				eb = tick.send_byte;
				if (tick.send_is_last) begin
					n.phase = PH_SEND_EOI;
				end else begin
					n.drv_clk = 1'b0;
					n.phase = PH_SEND_BITS;
				end
			end else if (n.phase == PH_SEND_EOI && 16'(n.quiet_clocks) > thr_eoi_tx) begin
				n.quiet_clocks = '0;
				n.drv_clk = 1'b0;
				n.phase = PH_SEND_BITS;
			end else if (n.phase == PH_SEND_BITS && 16'(n.quiet_clocks) > thr_bit) begin
				if (n.bit_valid) begin
					n.drv_data = n.shift_byte[n.bit_count[2:0]];
					n.drv_clk = 1'b1;
					n.bit_count = n.bit_count + 4'd1;
					if (n.bit_count == 4'd8) begin
						n.phase = PH_SEND_END;
					end
				end else begin
					n.drv_clk = 1'b0;
				end
				n.bit_valid = !n.bit_valid;
				n.quiet_clocks = '0;
			end else if (n.phase == PH_SEND_END && 16'(n.quiet_clocks) > thr_bit) begin
				n.drv_data = 1'b1;
				n.drv_clk = 1'b0;
				n.phase = PH_SEND_START;
				n.quiet_clocks = '0;
			end
		end else begin
			// a line changed: edge driven actions
			n.quiet_clocks = '0;
			if (!n.in_attention && atn) begin
				n.drv_data = 1'b0;
				n.phase = PH_ATN_WAIT;
				n.in_attention = 1'b1;
			end
			case (n.phase)
				PH_ATN_WAIT: begin
					if (!(n.drv_clk & hc)) begin
						n.phase = PH_READY;
					end
				end
				PH_READY: begin
					if (n.in_attention && !atn) begin
						n.drv_data = 1'b1;
						n.drv_clk = 1'b1;
						n.in_attention = 1'b0;
						if (n.is_listener) begin
							n.drv_data = 1'b0;
						end else if (n.is_talker) begin
							n.drv_clk = 1'b0;
							n.phase = PH_SEND_START;
						end else begin
							n.phase = PH_IDLE;
						end
					end else if (n.drv_clk & hc) begin
						n.drv_data = 1'b1;
						n.phase = PH_RECEIVE;
						n.bit_valid = 1'b1;
						n.bit_count = 4'd0;
						n.shift_byte = 8'd0;
						n.end_of_transfer = 1'b0;
					end
				end
				PH_RECEIVE: begin
					if (n.in_attention && !atn) begin
						n.drv_data = 1'b1;
						n.drv_clk = 1'b1;
						n.phase = PH_IDLE;
					end else if (n.bit_valid) begin
						if (!(n.drv_clk & hc)) begin
							n.bit_valid = 1'b0;
						end
					end else if (n.drv_clk & hc) begin
						n.shift_byte = n.shift_byte
							| (8'(n.drv_data & hd) << n.bit_count[2:0]);
						n.bit_valid = 1'b1;
						n.bit_count = n.bit_count + 4'd1;
						if (n.bit_count == 4'd8) begin
							if (n.in_attention) begin
								// command decode; group zero raises nothing
								case (n.shift_byte & CMD_GROUP_MASK)
									CMD_GROUP_LSN: begin
										if (n.shift_byte == CMD_UNLISTEN) begin
											ev = EV_UNLISTEN;
											n.file_missing = tick.unlisten_not_found;
											n.is_listener = 1'b0;
										end else begin
											ev = EV_LISTEN;
											n.is_listener = 1'b1;
										end
									end
									CMD_GROUP_TLK: begin
										if (n.shift_byte == CMD_UNTALK) begin
											ev = EV_UNTALK;
											n.is_talker = 1'b0;
										end else begin
											ev = EV_TALK;
											n.is_talker = 1'b1;
										end
									end
									CMD_GROUP_SEC: begin
										ev = n.is_listener ? EV_LISTEN_SEC : EV_TALK_SEC;
									end
									default: ;
								endcase
							end else begin
								ev = EV_DATA_IN;
							end
							if (ev != EV_NONE) begin
								eb = n.shift_byte;
							end
							n.drv_data = 1'b0;
							n.phase = PH_READY;
						end
					end
				end
				default: ;
			endcase
		end
		n.prev_lines = {atn, n.drv_clk & hc, n.drv_data & hd};
		nxt = n;
		res.drive_clk  = n.drv_clk;
		res.drive_data = n.drv_data;
		res.event_kind = ev;
		res.event_byte = eb;
	end

endmodule

// ===== rtl/iec_serial_bus_device_fsm.sv =====
// iec_serial_bus_device_fsm: top level of the serial bus device state machine.
// Holds the input register, device state and result register; uses iecsb_pkg, iecsb_step.

// Takes one bus sample tick per clock cycle while the result side does not stall and
// returns one result word per tick, in order. A tick is captured in the input register
// when accepted, and its result moves into the result register once that register is
// free, from where it is taken; the device state updates in that same single pass,
// which is what lets ticks follow in consecutive cycles. A stall on the result side
// holds the captured tick and backs up into in_ready. clocks_per_microsecond is
// written through cfg_we/cfg_wdata, resets to 8, and should only change while no
// tick is in flight. No memory clearing is needed after reset.
module iec_serial_bus_device_fsm (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	// tick input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       host_atn,
	input  logic       host_clk,
	input  logic       host_data,
	input  logic [7:0] elapsed_clocks,
	input  logic [7:0] send_byte,
	input  logic       send_is_last,
	input  logic       unlisten_not_found,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       drive_clk,
	output logic       drive_data,
	output logic [3:0] event_kind,
	output logic [7:0] event_byte
);
	import iecsb_pkg::*;

	logic          vld_s1;
	iecsb_tick_t   tick_s1;
	logic          vld_s2;
	iecsb_result_t res_s2;
	iecsb_state_t  st_q;
	iecsb_state_t  st_nxt;
	iecsb_result_t res_nxt;
	logic [6:0]    cpm_q;
	logic          advance;

	// handshake: the captured tick moves on when the result register frees up
	assign advance  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= CPM_RESET;
		end else if (cfg_we) begin
			cpm_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.host_atn           <= host_atn;
			tick_s1.host_clk           <= host_clk;
			tick_s1.host_data          <= host_data;
			tick_s1.elapsed_clocks     <= elapsed_clocks;
			tick_s1.send_byte          <= send_byte;
			tick_s1.send_is_last       <= send_is_last;
			tick_s1.unlisten_not_found <= unlisten_not_found;
		end
	end

	// tick logic
	iecsb_step u_step (
		.cpm  (cpm_q),
		.tick (tick_s1),
		.cur  (st_q),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	// device state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PH_IDLE;
			st_q.bit_valid       <= 1'b0;
			st_q.bit_count       <= 4'd0;
			st_q.shift_byte      <= 8'd0;
			st_q.is_listener     <= 1'b0;
			st_q.is_talker       <= 1'b0;
			st_q.in_attention    <= 1'b0;
			st_q.end_of_transfer <= 1'b0;
			st_q.file_missing    <= 1'b0;
			st_q.quiet_clocks    <= '0;
			st_q.prev_lines      <= 3'd0;
			st_q.drv_clk         <= 1'b0;
			st_q.drv_data        <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid  = vld_s2;
	assign drive_clk  = res_s2.drive_clk;
	assign drive_data = res_s2.drive_data;
	assign event_kind = res_s2.event_kind;
	assign event_byte = res_s2.event_byte;

endmodule

// ===== dv/tb_iec_serial_bus_device_fsm.sv =====
// tb_iec_serial_bus_device_fsm: self-checking bench for the serial bus device state machine.
// Acts as a reactive bus host, predicts every result word and checks them in order.
// Depends on iecsb_pkg and iec_serial_bus_device_fsm.
module tb_iec_serial_bus_device_fsm;
	import iecsb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_SETTING = 100;
	localparam int LONG_HOLD = 200;

	// predicted device state and the words it is expected to produce
	class bus_word_scoreboard;
		bit [6:0]     cpm;
		iecsb_phase_t phase;
		bit           bit_valid;
		bit [3:0]     bit_count;
		bit [7:0]     shift_byte;
		bit           is_listener;
		bit           is_talker;
		bit           in_attention;
		bit           end_of_transfer;
		bit           file_missing;
		int unsigned  quiet;
		bit [2:0]     prev_lines;
		bit           drv_clk;
		bit           drv_data;
		iecsb_result_t expected_words[$];
		int           mismatches;
		int           words_checked;

		function new();
			cpm = CPM_RESET;
			phase = PH_IDLE;
			bit_valid = 0;
			bit_count = 0;
			shift_byte = 0;
			is_listener = 0;
			is_talker = 0;
			in_attention = 0;
			end_of_transfer = 0;
			file_missing = 0;
			quiet = 0;
			prev_lines = 0;
			drv_clk = 0;
			drv_data = 0;
			mismatches = 0;
			words_checked = 0;
		endfunction

		// shared lines as seen by the device: own drive ANDed with host drive
		function bit [2:0] bus_lines(bit atn, bit hc, bit hd);
			return {atn, drv_clk & hc, drv_data & hd};
		endfunction

		function void decode_command(bit [7:0] b, bit nf, inout iecsb_event_t ev);
			case (b & CMD_GROUP_MASK)
				CMD_GROUP_LSN: begin
					if (b == CMD_UNLISTEN) begin
						ev = EV_UNLISTEN;
						file_missing = nf;
						is_listener = 0;
					end else begin
						ev = EV_LISTEN;
						is_listener = 1;
					end
				end
				CMD_GROUP_TLK: begin
					if (b == CMD_UNTALK) begin
						ev = EV_UNTALK;
						is_talker = 0;
					end else begin
						ev = EV_TALK;
						is_talker = 1;
					end
				end
				CMD_GROUP_SEC: ev = is_listener ? EV_LISTEN_SEC : EV_TALK_SEC;
				default: ;
			endcase
		endfunction

		// lines unchanged: timing driven behavior
		function void quiet_step(iecsb_tick_t t, inout iecsb_event_t ev, inout bit [7:0] eb);
			int unsigned m;
			m = 32'(cpm);
			// eoi acknowledge window while waiting for the first bit
			if (phase == PH_RECEIVE && bit_valid && bit_count == 0 && quiet > 200 * m) begin
				if (quiet < 260 * m) begin
					drv_data = 0;
					end_of_transfer = 1;
				end else begin
					drv_data = 1;
					quiet = 0;
				end
			end
			if (phase == PH_SEND_START && quiet > 60 * m) begin
				drv_clk = 1;
				phase = PH_SEND_WAIT;
				quiet = 0;
			end else if (phase == PH_SEND_WAIT && (drv_data & t.host_data) && !file_missing) begin
				quiet = 0;
				shift_byte = t.send_byte;
				end_of_transfer = t.send_is_last;
				bit_count = 0;
				bit_valid = 1;
				ev = EV_FETCH;
				eb = shift_byte;
				if (end_of_transfer) begin
					phase = PH_SEND_EOI;
				end else begin
					drv_clk = 0;
					phase = PH_SEND_BITS;
				end
			end else if (phase == PH_SEND_EOI && quiet > 512 * m) begin
				quiet = 0;
				drv_clk = 0;
				phase = PH_SEND_BITS;
			end else if (phase == PH_SEND_BITS && quiet > 60 * m) begin
				if (bit_valid) begin
					drv_data = shift_byte[bit_count[2:0]];
					drv_clk = 1;
					bit_count = bit_count + 4'd1;
					if (bit_count == 8)
						phase = PH_SEND_END;
				end else begin
					drv_clk = 0;
				end
				bit_valid = !bit_valid;
				quiet = 0;
			end else if (phase == PH_SEND_END && quiet > 60 * m) begin
				drv_data = 1;
				drv_clk = 0;
				phase = PH_SEND_START;
				quiet = 0;
			end
		endfunction

		// some line changed: edge driven behavior
		function void change_step(iecsb_tick_t t, inout iecsb_event_t ev, inout bit [7:0] eb);
			bit clk_high;
			quiet = 0;
			if (!in_attention && t.host_atn) begin
				drv_data = 0;
				phase = PH_ATN_WAIT;
				in_attention = 1;
			end
			clk_high = drv_clk & t.host_clk;
			case (phase)
				PH_ATN_WAIT: begin
					if (!clk_high)
						phase = PH_READY;
				end
				PH_READY: begin
					if (in_attention && !t.host_atn) begin
						drv_data = 1;
						drv_clk = 1;
						in_attention = 0;
						if (is_listener) begin
							drv_data = 0;
						end else if (is_talker) begin
							drv_clk = 0;
							phase = PH_SEND_START;
						end else begin
							phase = PH_IDLE;
						end
					end else if (clk_high) begin
						drv_data = 1;
						phase = PH_RECEIVE;
						bit_valid = 1;
						bit_count = 0;
						shift_byte = 0;
						end_of_transfer = 0;
					end
				end
				PH_RECEIVE: begin
					if (in_attention && !t.host_atn) begin
						drv_data = 1;
						drv_clk = 1;
						phase = PH_IDLE;
					end else if (bit_valid) begin
						if (!clk_high)
							bit_valid = 0;
					end else if (clk_high) begin
						shift_byte[bit_count[2:0]] = shift_byte[bit_count[2:0]] |
							(drv_data & t.host_data);
						bit_valid = 1;
						bit_count = bit_count + 4'd1;
						if (bit_count == 8) begin
							if (in_attention)
								decode_command(shift_byte, t.unlisten_not_found, ev);
							else
								ev = EV_DATA_IN;
							if (ev != EV_NONE)
								eb = shift_byte;
							drv_data = 0;
							phase = PH_READY;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void note_tick(iecsb_tick_t t);
			iecsb_event_t  ev;
			bit [7:0]      eb;
			iecsb_result_t w;
			ev = EV_NONE;
			eb = 0;
			if (bus_lines(t.host_atn, t.host_clk, t.host_data) == prev_lines) begin
				if (quiet > 32'hffff_ffff - t.elapsed_clocks)
					quiet = 32'hffff_ffff;
				else
					quiet = quiet + t.elapsed_clocks;
				quiet_step(t, ev, eb);
			end else begin
				change_step(t, ev, eb);
			end
			prev_lines = bus_lines(t.host_atn, t.host_clk, t.host_data);
			w.drive_clk = drv_clk;
			w.drive_data = drv_data;
			w.event_kind = ev;
			w.event_byte = eb;
			expected_words.push_back(w);
		endfunction

		function void check_word(iecsb_result_t got);
			iecsb_result_t want;
			if (expected_words.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: clk=%0b data=%0b ev=%0d byte=%02h",
						got.drive_clk, got.drive_data, got.event_kind, got.event_byte);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			if (got.drive_clk !== want.drive_clk || got.drive_data !== want.drive_data ||
				got.event_kind !== want.event_kind || got.event_byte !== want.event_byte) begin
				if (mismatches < 10)
					$display("word %0d: expected clk=%0b data=%0b ev=%0d byte=%02h, got clk=%0b data=%0b ev=%0d byte=%02h",
						words_checked, want.drive_clk, want.drive_data, want.event_kind,
						want.event_byte, got.drive_clk, got.drive_data, got.event_kind,
						got.event_byte);
				mismatches++;
			end
			words_checked++;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic       host_atn;
	logic       host_clk;
	logic       host_data;
	logic [7:0] elapsed_clocks;
	logic [7:0] send_byte;
	logic       send_is_last;
	logic       unlisten_not_found;
	logic       out_valid;
	logic       out_ready;
	logic       drive_clk;
	logic       drive_data;
	logic [3:0] event_kind;
	logic [7:0] event_byte;

	bus_word_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int ticks_sent;
	bit cur_atn, cur_hc, cur_hd;

	iec_serial_bus_device_fsm uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.host_atn(host_atn),
		.host_clk(host_clk),
		.host_data(host_data),
		.elapsed_clocks(elapsed_clocks),
		.send_byte(send_byte),
		.send_is_last(send_is_last),
		.unlisten_not_found(unlisten_not_found),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_clk(drive_clk),
		.drive_data(drive_data),
		.event_kind(event_kind),
		.event_byte(event_byte)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// offer one tick word and wait until it is taken
	task automatic push_tick(input bit atn, input bit hc, input bit hd, input bit [7:0] el);
		iecsb_tick_t t;
		t.host_atn = atn;
		t.host_clk = hc;
		t.host_data = hd;
		t.elapsed_clocks = el;
		t.send_byte = 8'($urandom_range(0, 255));
		t.send_is_last = ($urandom_range(0, 2) == 0);
		t.unlisten_not_found = ($urandom_range(0, 3) == 0);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		host_atn <= t.host_atn;
		host_clk <= t.host_clk;
		host_data <= t.host_data;
		elapsed_clocks <= t.elapsed_clocks;
		send_byte <= t.send_byte;
		send_is_last <= t.send_is_last;
		unlisten_not_found <= t.unlisten_not_found;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(t);
		cur_atn = atn;
		cur_hc = hc;
		cur_hd = hd;
		ticks_sent++;
	endtask

	function automatic bit [7:0] rnd_el();
		return 8'($urandom_range(0, 255));
	endfunction

	// stop sending and wait for every outstanding word
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_words.size() != 0);
	endtask

	task automatic write_scale(input bit [6:0] v);
		drain();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.cpm = v;
	endtask

	// a talker only hears commands while its clk drive is released
	task automatic wait_clk_released();
		int n;
		n = 0;
		while (!sb.drv_clk && sb.is_talker && !sb.in_attention && n < 400) begin
			push_tick(cur_atn, cur_hc, 1'b1, rnd_el());
			n++;
		end
	endtask

	// finish a byte under atn so that atn can drop safely
	task automatic finish_atn_byte();
		int n;
		n = 0;
		while (sb.in_attention && sb.phase == PH_RECEIVE && n < 20) begin
			push_tick(1'b1, ~cur_hc, cur_hd, rnd_el());
			n++;
		end
	endtask

	// one byte lsb first, optionally with the host eoi pause before it
	task automatic host_byte(input bit atn, input bit [7:0] b, input bit with_eoi);
		int n;
		push_tick(atn, 1'b0, 1'b1, rnd_el());
		push_tick(atn, 1'b1, 1'b1, rnd_el());
		if (with_eoi && sb.phase == PH_RECEIVE && sb.cpm != 0 && sb.cpm <= 16) begin
			n = 0;
			while (!sb.end_of_transfer && sb.phase == PH_RECEIVE && n < 60) begin
				push_tick(cur_atn, cur_hc, cur_hd, 8'($urandom_range(1, 255)));
				n++;
			end
			n = 0;
			while (!sb.drv_data && sb.phase == PH_RECEIVE && n < 60) begin
				push_tick(cur_atn, cur_hc, cur_hd, 8'($urandom_range(1, 255)));
				n++;
			end
		end
		for (int i = 0; i < 8; i++) begin
			push_tick(atn, 1'b0, b[i], rnd_el());
			push_tick(atn, 1'b1, b[i], rnd_el());
		end
	endtask

	function automatic bit [7:0] random_command();
		int k;
		bit [7:0] r5;
		bit [7:0] b;
		k = $urandom_range(0, 99);
		r5 = 8'($urandom_range(0, 31));
		if (k < 25)
			b = CMD_GROUP_LSN | r5;
		else if (k < 40)
			b = CMD_UNLISTEN;
		else if (k < 60)
			b = CMD_GROUP_TLK | r5;
		else if (k < 72)
			b = CMD_UNTALK;
		else if (k < 88)
			b = CMD_GROUP_SEC | r5;
		else
			b = r5;
		// top bit is outside the command group field
		if ($urandom_range(0, 3) == 0)
			b[7] = 1'b1;
		return b;
	endfunction

	// atn asserted, n command bytes, atn released
	task automatic atn_command(input int n);
		wait_clk_released();
		finish_atn_byte();
		if (cur_atn)
			push_tick(1'b0, cur_hc, 1'b1, rnd_el());
		push_tick(1'b1, 1'b0, 1'b1, rnd_el());
		repeat (n) host_byte(1'b1, random_command(), 1'b0);
		push_tick(1'b0, 1'($urandom_range(0, 1)), 1'b1, rnd_el());
	endtask

	task automatic listener_data(input int n);
		repeat (n) host_byte(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
	endtask

	// mostly quiet ticks so the talker can time its bits, with a few glitches
	task automatic talker_service(input int n);
		int k;
		push_tick(1'b0, cur_hc, 1'b1, rnd_el());
		repeat (n) begin
			k = $urandom_range(0, 99);
			if (k < 6)
				push_tick(1'b0, ~cur_hc, cur_hd, rnd_el());
			else if (k < 12)
				push_tick(1'b0, cur_hc, ~cur_hd, rnd_el());
			else
				push_tick(1'b0, cur_hc, cur_hd, 8'($urandom_range(128, 255)));
		end
	endtask

	// random lines; atn is kept up while a command byte is being shifted in
	task automatic bus_noise(input int n);
		bit a;
		repeat (n) begin
			a = 1'($urandom_range(0, 1));
			if (sb.in_attention && sb.phase == PH_RECEIVE)
				a = 1'b1;
			push_tick(a, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rnd_el());
		end
	endtask

	task automatic run_random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			bus_noise($urandom_range(1, 6));
		end else if (pick < 45) begin
			atn_command($urandom_range(1, 3));
		end else if (pick < 70) begin
			if (sb.is_listener && sb.phase == PH_READY && !sb.in_attention && !cur_atn)
				listener_data($urandom_range(1, 4));
			else
				atn_command(1);
		end else begin
			if (sb.is_talker && !sb.in_attention)
				talker_service($urandom_range(6, 40));
			else
				atn_command(1);
		end
	endtask

	// atn dropped in the middle of a command byte leaves the device deaf, so it comes last
	task automatic mid_byte_release();
		wait_clk_released();
		finish_atn_byte();
		if (cur_atn)
			push_tick(1'b0, cur_hc, 1'b1, rnd_el());
		push_tick(1'b1, 1'b0, 1'b1, rnd_el());
		push_tick(1'b1, 1'b1, 1'b1, rnd_el());
		repeat (3) begin
			push_tick(1'b1, 1'b0, 1'b1, rnd_el());
			push_tick(1'b1, 1'b1, 1'b0, rnd_el());
		end
		push_tick(1'b0, 1'b1, 1'b0, rnd_el());
		// later atn edges must start nothing
		push_tick(1'b1, 1'b0, 1'b1, rnd_el());
		push_tick(1'b0, 1'b1, 1'b1, rnd_el());
		push_tick(1'b1, 1'b0, 1'b1, rnd_el());
		push_tick(1'b1, 1'b1, 1'b1, rnd_el());
		push_tick(1'b0, 1'b1, 1'b1, 8'd255);
		push_tick(1'b0, 1'b1, 1'b1, 8'd255);
	endtask

	// result side: check accepted words, random or long stalls
	initial begin
		iecsb_result_t got;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.drive_clk = drive_clk;
				got.drive_data = drive_data;
				got.event_kind = event_kind;
				got.event_byte = event_byte;
				sb.check_word(got);
			end
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				recv_hold--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int p;
		int limit;
		bit hold_done;
		bit pause_done;
		bit [6:0] scales [6];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		host_atn = 1'b0;
		host_clk = 1'b0;
		host_data = 1'b0;
		elapsed_clocks = '0;
		send_byte = '0;
		send_is_last = 1'b0;
		unlisten_not_found = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 46;
		recv_hold = 0;
		ticks_sent = 0;
		cur_atn = 0;
		cur_hc = 0;
		cur_hd = 0;
		hold_done = 0;
		pause_done = 0;
		scales[0] = CPM_RESET;
		scales[1] = 7'd1;
		scales[2] = 7'd64;
		scales[3] = 7'd0;
		scales[4] = 7'($urandom_range(2, 63));
		scales[5] = 7'd127;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: quiet ticks at elapsed extremes, bare atn, group zero command
		push_tick(1'b0, 1'b1, 1'b1, 8'd0);
		push_tick(1'b0, 1'b1, 1'b1, 8'd255);
		push_tick(1'b1, 1'b0, 1'b1, 8'd0);
		push_tick(1'b0, 1'b1, 1'b1, 8'd255);
		push_tick(1'b1, 1'b0, 1'b1, rnd_el());
		host_byte(1'b1, 8'h00, 1'b0);
		push_tick(1'b0, 1'b1, 1'b1, rnd_el());

		// random part, one clock scale per stretch
		for (p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p > 0)
				write_scale(scales[p]);
			limit = ticks_sent + ITEMS_PER_SETTING;
			while (ticks_sent < limit) begin
				if (p == 1 && !hold_done && ticks_sent > limit - 60) begin
					recv_hold = LONG_HOLD;
					hold_done = 1;
				end
				if (p == 3 && !pause_done && ticks_sent > limit - 50) begin
					drain();
					pause_done = 1;
				end
				run_random_sequence();
			end
		end
		mid_byte_release();

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
